// ----- hw/rtl/lrle_pkg.sv -----
// ----------------------------------------------------------------------------
// lrle_pkg
// Word types and constants shared by the level run-length encoder.
// ----------------------------------------------------------------------------
package lrle_pkg;

  localparam int unsigned SampleW   = 8;
  localparam int unsigned GapW      = 24;
  localparam int unsigned CountW    = 32;
  localparam int unsigned DurW      = 40;
  localparam int unsigned RunW      = 7;

  // sample bit that selects the level (level is high when it is clear)
  localparam int unsigned LevelBit  = 7;

  localparam logic [RunW-1:0]   RunMax   = 7'h7f;
  localparam logic [GapW-1:0]   GapReset = 24'd22050;
  localparam logic [CountW-1:0] Max32    = '1;
  localparam logic [DurW-1:0]   Max40    = '1;
  // duration step per sample, in half-sample units
  localparam logic [DurW-1:0]   DurStep  = 40'd2;

  typedef enum logic [1:0] {
    KIND_RUN  = 2'd0,
    KIND_DESC = 2'd1,
    KIND_TERM = 2'd2
  } kind_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               end_of_stream;
  } in_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         run_byte;
    logic [CountW-1:0]  block_offset;
    logic [CountW-1:0]  block_size;
    logic [DurW-1:0]    block_duration;
    logic               last_result;
  } out_word_t;

endpackage

// ----- hw/rtl/level_run_length_encoder.sv -----
// ----------------------------------------------------------------------------
// level_run_length_encoder
// Turns audio samples into level run bytes and emits a block descriptor
// whenever a long enough pause or the end of stream closes a block.
// ----------------------------------------------------------------------------
//  port group    dir   handshake                 word
//  in_*          in    in_valid_i / in_stall_o   in_word_t (sample, end_of_stream)
//  out_*         out   out_valid_o / out_stall_i out_word_t (kind ... last_result)
//  cfg_*         in    cfg_we_i                  gap_samples, 24 bits
//
//  one input word is taken per cycle while the output buffer has room; it waits in
//  the input register and its results are registered into a two-entry output buffer.
//  a word with two results (block split, end of stream) holds off the next input
//  word while the output buffer drains.
//  reset clears the encoder state and sets gap_samples to 22050.
//  in_stall_o follows out_stall_i in the same cycle when the buffer holds one word.
// ----------------------------------------------------------------------------
module level_run_length_encoder
  import lrle_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,

  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_word_t        in_word_i,

  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_word_t       out_word_o,

  input  logic            cfg_we_i,
  input  logic [GapW-1:0] cfg_wdata_i
);

  function automatic logic [CountW-1:0] sat_inc32(input logic [CountW-1:0] v);
    return (v == Max32) ? v : v + 1'b1;
  endfunction

  function automatic out_word_t run_word(input logic lvl, input logic [RunW-1:0] len,
                                         input logic last);
    out_word_t w;
    w = '0;
    w.kind        = KIND_RUN;
    w.run_byte    = {lvl, len};
    w.last_result = last;
    return w;
  endfunction

  function automatic out_word_t desc_word(input logic [CountW-1:0] off,
                                          input logic [CountW-1:0] size,
                                          input logic [DurW-1:0] dur,
                                          input logic last);
    out_word_t w;
    w = '0;
    w.kind           = KIND_DESC;
    w.block_offset   = off;
    w.block_size     = size;
    w.block_duration = dur;
    w.last_result    = last;
    return w;
  endfunction

  // configuration
  logic [GapW-1:0] gap_q;

  // input register
  logic     in_valid_q;
  in_word_t in_word_q;

  // encoder state
  logic              started_q, started_d;
  logic              level_q, level_d;
  logic [RunW-1:0]   run_len_q, run_len_d;
  logic [CountW-1:0] pause_samples_q, pause_samples_d;
  logic [CountW-1:0] pause_bytes_q, pause_bytes_d;
  logic [CountW-1:0] byte_offset_q, byte_offset_d;
  logic [CountW-1:0] block_start_q, block_start_d;
  logic [DurW-1:0]   dur_acc_q, dur_acc_d;

  // output buffer, slot 0 is the head
  out_word_t slot0_q, slot1_q;
  logic [1:0] cnt_q;

  logic pop, room, adv;
  logic [1:0] n_res;
  out_word_t res0, res1;

  logic              level_in;
  logic [DurW:0]     dur_sum;
  logic [DurW-1:0]   dur_inc;
  logic [RunW-1:0]   run_inc;
  logic [CountW-1:0] half;
  logic [CountW-1:0] span;
  logic [CountW-1:0] split_size;
  logic [DurW-1:0]   split_dur;
  logic [DurW-1:0]   pause_wide;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign room        = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign adv         = in_valid_q && room;
  assign in_stall_o  = in_valid_q && !room;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = slot0_q;

  assign level_in   = ~in_word_q.sample[LevelBit];
  assign dur_sum    = {1'b0, dur_acc_q} + {1'b0, DurStep};
  assign dur_inc    = dur_sum[DurW] ? Max40 : dur_sum[DurW-1:0];
  assign run_inc    = run_len_q + 1'b1;
  assign half       = pause_bytes_q >> 1;
  assign span       = (byte_offset_q >= block_start_q) ? byte_offset_q - block_start_q : '0;
  assign split_size = (span >= half) ? span - half : '0;
  assign pause_wide = {{(DurW-CountW){1'b0}}, pause_samples_q};
  assign split_dur  = (dur_inc >= pause_wide) ? dur_inc - pause_wide : '0;

  always_comb begin
    started_d       = started_q;
    level_d         = level_q;
    run_len_d       = run_len_q;
    pause_samples_d = pause_samples_q;
    pause_bytes_d   = pause_bytes_q;
    byte_offset_d   = byte_offset_q;
    block_start_d   = block_start_q;
    dur_acc_d       = dur_acc_q;
    n_res           = 2'd0;
    res0            = '0;
    res1            = '0;

    if (in_word_q.end_of_stream) begin
      res0      = '0;
      res0.kind = KIND_TERM;
      res1      = desc_word(block_start_q, span, dur_acc_q, 1'b1);
      n_res     = 2'd2;
      started_d       = 1'b0;
      level_d         = 1'b0;
      run_len_d       = 7'd1;
      pause_samples_d = '0;
      pause_bytes_d   = '0;
      byte_offset_d   = '0;
      block_start_d   = '0;
      dur_acc_d       = '0;
    end else if (!started_q) begin
      started_d = 1'b1;
      level_d   = level_in;
      run_len_d = 7'd1;
      dur_acc_d = DurStep;
    end else begin
      dur_acc_d = dur_inc;
      if (level_in == level_q) begin
        pause_samples_d = sat_inc32(pause_samples_q);
        if (run_inc == RunMax) begin
          // full run is flushed and counts toward the pause
          res0          = run_word(level_q, RunMax, 1'b1);
          n_res         = 2'd1;
          byte_offset_d = sat_inc32(byte_offset_q);
          pause_bytes_d = sat_inc32(pause_bytes_q);
          run_len_d     = '0;
        end else begin
          run_len_d = run_inc;
        end
      end else begin
        if (pause_samples_q >= {{(CountW-GapW){1'b0}}, gap_q}) begin
          // block splits at half the pause
          res0          = desc_word(block_start_q, split_size, split_dur, 1'b0);
          res1          = run_word(level_q, run_len_q, 1'b1);
          n_res         = 2'd2;
          block_start_d = (byte_offset_q >= half) ? byte_offset_q - half : '0;
          dur_acc_d     = pause_wide;
        end else begin
          res0  = run_word(level_q, run_len_q, 1'b1);
          n_res = 2'd1;
        end
        byte_offset_d   = sat_inc32(byte_offset_q);
        pause_samples_d = '0;
        pause_bytes_d   = '0;
        level_d         = level_in;
        run_len_d       = 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q           <= GapReset;
      in_valid_q      <= 1'b0;
      started_q       <= 1'b0;
      level_q         <= 1'b0;
      run_len_q       <= 7'd1;
      pause_samples_q <= '0;
      pause_bytes_q   <= '0;
      byte_offset_q   <= '0;
      block_start_q   <= '0;
      dur_acc_q       <= '0;
      cnt_q           <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        started_q       <= started_d;
        level_q         <= level_d;
        run_len_q       <= run_len_d;
        pause_samples_q <= pause_samples_d;
        pause_bytes_q   <= pause_bytes_d;
        byte_offset_q   <= byte_offset_d;
        block_start_q   <= block_start_d;
        dur_acc_q       <= dur_acc_d;
        cnt_q           <= n_res;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
    if (adv) begin
      slot0_q <= res0;
      slot1_q <= res1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  // terminator leaves only with the final descriptor right behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.kind == KIND_TERM) |->
      (cnt_q == 2'd2 && slot1_q.kind == KIND_DESC && slot1_q.last_result))
    else $error("terminator not followed by final descriptor");

  // first of two buffered results is never the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !slot0_q.last_result)
    else $error("last_result set on first of two results");

  // end of stream returns the encoder to its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_word_q.end_of_stream) |=>
      (!started_q && byte_offset_q == '0 && block_start_q == '0 && dur_acc_q == '0))
    else $error("state not cleared after end of stream");

  // a full buffer never goes straight to empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |=> (cnt_q != 2'd0 || $past(pop)))
    else $error("output buffer lost a result");

endmodule
